// ===== hdl/wrp_pkg.sv =====
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and constants for the WAV RIFF header parser.
// ----------------------------------------------------------------------------
package wrp_pkg;

	// offsets and byte counts
	localparam int unsigned OFFSET_BITS = 32;
	localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
	localparam logic [31:0] MIN_LEN = 32'd44;
	localparam logic [31:0] FIRST_CHUNK = 32'd12;
	localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
	localparam logic [31:0] HDR_LEN = 32'd8;

	// chunk identifiers, little-endian as shifted in
	localparam logic [31:0] ID_FMT = 32'h2074_6D66;
	localparam logic [31:0] ID_DATA = 32'h6174_6164;

	// reset values
	localparam logic [17:0] DEFAULT_RATE_RST = 18'd44100;
	localparam logic [15:0] BITS_RST = 16'd16;

	// configuration register map (word index)
	localparam logic REG_DEFAULT_RATE = 1'b0;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_NO_RIFF = 2'd2,
		ST_NO_WAVE = 2'd3
	} status_t;

	// magic bytes: "RIFF" at 0..3, "WAVE" at 8..11
	function automatic logic [7:0] riff_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h52;
			2'd1:    r = 8'h49;
			default: r = 8'h46;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] wave_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h57;
			2'd1:    r = 8'h41;
			2'd2:    r = 8'h56;
			default: r = 8'h45;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/wav_riff_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// wav_riff_header_parser_core
// Streams a WAV file byte by byte and reports format and PCM location.
// ----------------------------------------------------------------------------
// The file enters one byte per transfer, with last set on its final byte. One
// byte is taken in every clock cycle unless the input stalls: each byte lands
// in an input register and compare and add logic then updates the parse state
// from it, and the final byte from the input register loads the result into
// the output register. Non-final bytes never wait for the result side; a final
// byte is held in the input register, stalling the input, only while the
// previous result still waits to be taken. After each result the parser
// returns to its start state. The default sample rate register is kept; the
// value it holds when the final byte is processed is the one reported for a
// file with OK status that carried no fmt chunk.
module wav_riff_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] audio_rate,
	output logic [15:0] bits_per_sample,
	output logic        data_found,
	output logic [31:0] pcm_offset,
	output logic [31:0] pcm_length
);
	import wrp_pkg::*;

	// configuration register
	logic [17:0] default_rate_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// parse state
	logic [31:0] byte_count_q;
	logic [1:0]  magic_q;
	logic [31:0] next_off_q;
	logic [31:0] id_q;
	logic [31:0] size_q;
	logic        in_fmt_q;
	logic [31:0] rate_q;
	logic [15:0] bits_q;
	logic        data_seen_q;
	logic [31:0] pcm_off_q;
	logic [31:0] pcm_len_q;
	logic [31:0] cur_q;
	logic        fmt_seen_q;

	// next parse state
	logic [1:0]  magic_d;
	logic [31:0] next_off_d;
	logic [31:0] id_d;
	logic [31:0] size_d;
	logic        in_fmt_d;
	logic [31:0] rate_d;
	logic [15:0] bits_d;
	logic        data_seen_d;
	logic [31:0] pcm_off_d;
	logic [31:0] pcm_len_d;
	logic [31:0] cur_d;
	logic        fmt_seen_d;

	// result register
	logic        out_valid_q;
	status_t     status_q;
	logic [31:0] rate_out_q;
	logic [15:0] bits_out_q;
	logic        found_q;
	logic [31:0] off_out_q;
	logic [31:0] len_out_q;

	// datapath helpers
	logic        parse_en;
	logic [31:0] total;
	logic [31:0] rel;
	logic [32:0] hdr_diff;
	logic        hdr_hit;
	logic [2:0]  hdr_pos;
	logic [31:0] size_new;
	logic [33:0] nxt_sum;
	logic [32:0] body_sum;
	status_t     status_d;

	// handshake
	logic        in_fire;
	logic        s1_adv;
	logic        s1_fire;

	// ------------------------------------------------------------------------
	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEFAULT_RATE) ? {14'd0, default_rate_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_rate_q <= DEFAULT_RATE_RST;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_DEFAULT_RATE) begin
			default_rate_q <= pwdata[17:0];
		end
	end

	// ------------------------------------------------------------------------
	// flow control: a non-final byte never waits for the result register
	assign s1_adv   = !last_s1 || !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && s1_adv;
	assign in_stall = valid_s1 && !s1_adv;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
		end
	end

	// ------------------------------------------------------------------------
	// per-byte parse logic
	assign parse_en = (byte_count_q != OFF_MAX);
	assign total    = parse_en ? byte_count_q + 32'd1 : byte_count_q;
	assign rel      = byte_count_q - cur_q;
	assign hdr_diff = {1'b0, byte_count_q} - {1'b0, next_off_q};
	assign hdr_hit  = parse_en && !data_seen_q && (next_off_q != OFF_MAX) &&
		!hdr_diff[32] && (hdr_diff[31:3] == 29'd0);
	assign hdr_pos  = hdr_diff[2:0];
	assign size_new = {byte_s1, size_q[31:8]};
	assign nxt_sum  = {2'b00, next_off_q} + {2'b00, HDR_LEN} + {2'b00, size_new};
	assign body_sum = {1'b0, next_off_q} + {1'b0, HDR_LEN};

	always_comb begin
		magic_d     = magic_q;
		next_off_d  = next_off_q;
		id_d        = id_q;
		size_d      = size_q;
		in_fmt_d    = in_fmt_q;
		rate_d      = rate_q;
		bits_d      = bits_q;
		data_seen_d = data_seen_q;
		pcm_off_d   = pcm_off_q;
		pcm_len_d   = pcm_len_q;
		cur_d       = cur_q;
		fmt_seen_d  = fmt_seen_q;

		// magic checks
		if (parse_en && byte_count_q[31:2] == 30'd0 && byte_s1 != riff_byte(byte_count_q[1:0]))
			magic_d[0] = 1'b0;
		if (parse_en && byte_count_q[31:2] == 30'd2 && byte_s1 != wave_byte(byte_count_q[1:0]))
			magic_d[1] = 1'b0;

		// fmt body: rate at bytes 12..15, bit depth at 22..23
		if (parse_en && in_fmt_q && byte_count_q > cur_q) begin
			if (rel[31:2] == 30'd3) begin
				for (int i = 0; i < 4; i++) begin
					if (rel[1:0] == i[1:0])
						rate_d[8*i +: 8] = byte_s1;
				end
			end else if (rel[31:1] == 31'd11) begin
				if (rel[0])
					bits_d[15:8] = byte_s1;
				else
					bits_d[7:0] = byte_s1;
			end
		end

		// chunk header walk
		if (hdr_hit) begin
			if (hdr_pos == 3'd0) begin
				in_fmt_d = 1'b0;
				cur_d    = next_off_q;
			end
			if (!hdr_pos[2])
				id_d = {byte_s1, id_q[31:8]};
			else
				size_d = size_new;
			if (hdr_pos == 3'd7) begin
				if (id_q == ID_FMT && size_new >= FMT_MIN_SIZE) begin
					in_fmt_d   = 1'b1;
					fmt_seen_d = 1'b1;
				end else if (id_q == ID_DATA) begin
					data_seen_d = 1'b1;
					pcm_off_d   = body_sum[32] ? OFF_MAX : body_sum[31:0];
					pcm_len_d   = size_new;
				end
				next_off_d = (nxt_sum[33:32] != 2'd0) ? OFF_MAX : nxt_sum[31:0];
			end
		end

		// final status, checks in priority order
		if (total < MIN_LEN)
			status_d = ST_SHORT;
		else if (!magic_d[0])
			status_d = ST_NO_RIFF;
		else if (!magic_d[1])
			status_d = ST_NO_WAVE;
		else
			status_d = ST_OK;
	end

	// ------------------------------------------------------------------------
	// parse state, cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= 32'd0;
			magic_q      <= 2'b11;
			next_off_q   <= FIRST_CHUNK;
			id_q         <= 32'd0;
			size_q       <= 32'd0;
			in_fmt_q     <= 1'b0;
			rate_q       <= {14'd0, DEFAULT_RATE_RST};
			bits_q       <= BITS_RST;
			data_seen_q  <= 1'b0;
			pcm_off_q    <= 32'd0;
			pcm_len_q    <= 32'd0;
			cur_q        <= 32'd0;
			fmt_seen_q   <= 1'b0;
		end else if (s1_fire) begin
			if (last_s1) begin
				byte_count_q <= 32'd0;
				magic_q      <= 2'b11;
				next_off_q   <= FIRST_CHUNK;
				id_q         <= 32'd0;
				size_q       <= 32'd0;
				in_fmt_q     <= 1'b0;
				rate_q       <= {14'd0, default_rate_q};
				bits_q       <= BITS_RST;
				data_seen_q  <= 1'b0;
				pcm_off_q    <= 32'd0;
				pcm_len_q    <= 32'd0;
				cur_q        <= 32'd0;
				fmt_seen_q   <= 1'b0;
			end else begin
				byte_count_q <= total;
				magic_q      <= magic_d;
				next_off_q   <= next_off_d;
				id_q         <= id_d;
				size_q       <= size_d;
				in_fmt_q     <= in_fmt_d;
				rate_q       <= rate_d;
				bits_q       <= bits_d;
				data_seen_q  <= data_seen_d;
				pcm_off_q    <= pcm_off_d;
				pcm_len_q    <= pcm_len_d;
				cur_q        <= cur_d;
				fmt_seen_q   <= fmt_seen_d;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			status_q <= status_d;
			if (status_d != ST_OK) begin
				rate_out_q <= 32'd0;
				bits_out_q <= 16'd0;
				found_q    <= 1'b0;
				off_out_q  <= 32'd0;
				len_out_q  <= 32'd0;
			end else begin
				rate_out_q <= fmt_seen_d ? rate_d : {14'd0, default_rate_q};
				bits_out_q <= bits_d;
				found_q    <= data_seen_d;
				off_out_q  <= data_seen_d ? pcm_off_d : MIN_LEN;
				len_out_q  <= data_seen_d ? pcm_len_d : total - MIN_LEN;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign audio_rate      = rate_out_q;
	assign bits_per_sample = bits_out_q;
	assign data_found      = found_q;
	assign pcm_offset      = off_out_q;
	assign pcm_length      = len_out_q;

endmodule
